### hw/rtl/mm3_pkg.sv
// Shared constants, types and helpers for the MurmurHash3 x86_32 block.
`default_nettype none

package mm3_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] MixC1  = 32'hcc9e2d51;
  localparam logic [HashW-1:0] MixC2  = 32'h1b873593;
  localparam logic [HashW-1:0] MixAdd = 32'he6546b64;
  localparam logic [HashW-1:0] FinM1  = 32'h85ebca6b;
  localparam logic [HashW-1:0] FinM2  = 32'hc2b2ae35;

  // configuration register indexes
  localparam logic [1:0] RegSeed     = 2'd0;
  localparam logic [1:0] RegZeroSeed = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K2,
    S_HMIX,
    S_T1,
    S_T2,
    S_F0,
    S_F1,
    S_OUT
  } mm3_state_t;

  function automatic logic [HashW-1:0] rotl15(input logic [HashW-1:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [HashW-1:0] rotl13(input logic [HashW-1:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mm3_mul.sv
// Shared 32x32 multiplier, low word of the product registered.
`default_nettype none

module mm3_mul
  import mm3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [HashW-1:0] op_a,
  input  wire logic [HashW-1:0] op_b,
  output logic      [HashW-1:0] prod
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= op_a * op_b;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/murmur3_32_hash_top.sv
// Top level of the streaming MurmurHash3 x86_32 hasher: sequencer and state.
`default_nettype none

// Hashes a byte stream, one byte per input transaction, and delivers the
// 32-bit MurmurHash3 (x86_32) on the output channel once the transaction
// with last set has been taken in. A transaction with byte_valid low adds
// no byte; with last set it closes the message, so an empty message can be
// hashed. All multiplications go through one shared 32x32 multiplier under
// a small sequencer, and in_stall is high while a sequence runs. A byte that
// does not complete a 4-byte block starts no multiply of its own; the byte
// that completes a block runs two multiplies, then the rotate and h*5+c
// update. Closing a message adds the tail mix when 1 to 3 bytes are left
// over, then the two finaliser multiplies and the step that loads the output
// register. The output register lets a new message start while a result
// still waits; a second result waits in the last step until the first has
// gone. seed and zero_seed_value are written through a plain write port; the
// user must write them only while the block is idle, and the block itself
// does not enforce this. Any write to either restarts the message.
// A seed of zero selects zero_seed_value.

module murmur3_32_hash_top
  import mm3_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [HashW-1:0] cfg_data,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] data_byte,
  input  wire logic             byte_valid,
  input  wire logic             last,
  // output channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [HashW-1:0] hash_value
);

  mm3_state_t state, state_next;

  logic [HashW-1:0] seed, zero_seed_value;
  logic [HashW-1:0] hash_acc;
  logic             fresh;      // hash_acc still to come from the registers
  logic [23:0]      pending_bytes;
  logic [1:0]       byte_pos;
  logic [HashW-1:0] total_length;
  logic             last_q;

  logic [HashW-1:0] hash_eff;
  logic [HashW-1:0] prod;
  logic [HashW-1:0] op_a, op_b;
  logic             mul_load;
  logic             in_take;
  logic             out_free;
  logic [HashW-1:0] fin_h0, fin_x0, mix_r;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign hash_eff = fresh ? ((seed != '0) ? seed : zero_seed_value) : hash_acc;

  // finaliser first step: tail fold, length fold, shift-xor 16
  assign fin_h0 = hash_eff ^ ((byte_pos != 2'd0) ? prod : '0) ^ total_length;
  assign fin_x0 = fin_h0 ^ (fin_h0 >> 16);
  assign mix_r  = rotl13(hash_eff ^ prod);

  // sequencer and multiplier operand selection
  always_comb begin
    state_next = state;
    mul_load   = 1'b0;
    op_a       = prod;
    op_b       = MixC2;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (byte_valid && byte_pos == 2'd3) begin
            mul_load   = 1'b1;
            op_a       = {data_byte, pending_bytes};
            op_b       = MixC1;
            state_next = S_K2;
          end else if (last) begin
            if (byte_valid || byte_pos != 2'd0) begin
              state_next = S_T1;
            end else begin
              state_next = S_F0;
            end
          end
        end
      end
      S_K2: begin
        mul_load   = 1'b1;
        op_a       = rotl15(prod);
        op_b       = MixC2;
        state_next = S_HMIX;
      end
      S_HMIX: begin
        state_next = last_q ? S_F0 : S_IDLE;
      end
      S_T1: begin
        mul_load   = 1'b1;
        op_a       = {8'd0, pending_bytes};
        op_b       = MixC1;
        state_next = S_T2;
      end
      S_T2: begin
        mul_load   = 1'b1;
        op_a       = rotl15(prod);
        op_b       = MixC2;
        state_next = S_F0;
      end
      S_F0: begin
        mul_load   = 1'b1;
        op_a       = fin_x0;
        op_b       = FinM1;
        state_next = S_F1;
      end
      S_F1: begin
        mul_load   = 1'b1;
        op_a       = prod ^ (prod >> 13);
        op_b       = FinM2;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  mm3_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // message state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seed            <= '0;
      zero_seed_value <= '0;
      fresh           <= 1'b1;
      pending_bytes   <= '0;
      byte_pos        <= '0;
      total_length    <= '0;
      last_q          <= 1'b0;
    end else if (cfg_write && (cfg_index == RegSeed || cfg_index == RegZeroSeed)) begin
      if (cfg_index == RegSeed) begin
        seed <= cfg_data;
      end else begin
        zero_seed_value <= cfg_data;
      end
      fresh         <= 1'b1;
      pending_bytes <= '0;
      byte_pos      <= '0;
      total_length  <= '0;
    end else begin
      if (in_take) begin
        last_q <= last;
        if (byte_valid) begin
          total_length <= total_length + 32'd1;
          case (byte_pos)
            2'd0:    pending_bytes[7:0]   <= data_byte;
            2'd1:    pending_bytes[15:8]  <= data_byte;
            2'd2:    pending_bytes[23:16] <= data_byte;
            default: pending_bytes        <= '0;
          endcase
          byte_pos <= byte_pos + 2'd1;
        end
      end
      if (state == S_HMIX) begin
        fresh <= 1'b0;
      end
      if (state == S_OUT && out_free) begin
        fresh         <= 1'b1;
        pending_bytes <= '0;
        byte_pos      <= '0;
        total_length  <= '0;
      end
    end
  end

  // running hash, h = rotl13(h ^ k) * 5 + c
  always_ff @(posedge clk) begin
    if (state == S_HMIX) begin
      hash_acc <= (mix_r << 2) + mix_r + MixAdd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      hash_value <= prod ^ (prod >> 16);
    end
  end

endmodule

`default_nettype wire
